// ===== sv/wpld_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the windowed ppb lock detector.
// No dependencies; every other file of the block uses it by scoped names.
package wpld_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int CLOCK_W     = 28;
   localparam int THR_W       = 27;
   localparam int PPB_W       = 32;
   localparam int STAB_W      = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 28;

   // 1e11 = 1e9 (ppb) * 100, split so each partial product stays narrow
   localparam int SCALE_W     = 37;
   localparam int SCALE_LO_W  = 19;
   localparam int SCALE_HI_W  = SCALE_W - SCALE_LO_W;
   localparam logic [SCALE_W-1:0]    PPB_SCALE    = 37'd100000000000;
   localparam logic [SCALE_LO_W-1:0] PPB_SCALE_LO = SCALE_LO_W'(PPB_SCALE);
   localparam logic [SCALE_HI_W-1:0] PPB_SCALE_HI = SCALE_HI_W'(PPB_SCALE >> SCALE_LO_W);

   localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET  = 28'd10000000;
   localparam logic [THR_W-1:0]   THRESHOLD_RESET = 27'd100;

   typedef enum logic [STAB_W-1:0] {
      STAB_UNSTABLE = 2'd0,
      STAB_MARGINAL = 2'd1,
      STAB_STABLE   = 2'd2
   } stab_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLOCK_HZ       = 1'b0,
      CSR_LOCK_THRESHOLD = 1'b1
   } csr_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ===== sv/wpld_chan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the windowed ppb lock detector.
// Depends on wpld_pkg for the payload widths.
interface wpld_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [wpld_pkg::SAMPLE_W-1:0] error_cycles;

   modport source (output valid, output error_cycles, input ready);
   modport sink   (input valid, input error_cycles, output ready);
endinterface

interface wpld_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [wpld_pkg::PPB_W-1:0] ppb_x100;
   logic                              ppb_changed;
   logic [wpld_pkg::STAB_W-1:0]       stability;
   logic                              lock_out_n;

   modport source (output valid, output ppb_x100, output ppb_changed,
                   output stability, output lock_out_n, input ready);
   modport sink   (input valid, input ppb_x100, input ppb_changed,
                   input stability, input lock_out_n, output ready);
endinterface

// ===== sv/wpld_ring.sv =====
`timescale 1ns / 1ps
// Sample ring memory: one write port, one read port with registered data.
// Depends on wpld_pkg for the sample width.
module wpld_ring #(
   parameter int  DEPTH = 128,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic                                 clock,
   input  logic                                 rd_en,
   input  logic [IDX_W-1:0]                     rd_idx,
   output logic signed [wpld_pkg::SAMPLE_W-1:0] rd_data_ff,
   input  logic                                 wr_en,
   input  logic [IDX_W-1:0]                     wr_idx,
   input  logic signed [wpld_pkg::SAMPLE_W-1:0] wr_data
);

   logic signed [wpld_pkg::SAMPLE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx];
      end
   end

endmodule

// ===== sv/wpld_div.sv =====
`timescale 1ns / 1ps
// Serial restoring divider for unsigned operands, one quotient bit per cycle.
// Depends on wpld_pkg for the status struct.
module wpld_div #(
   parameter int  NUM_W = 56,
   parameter int  DEN_W = 36,
   localparam int CNT_W = $clog2(NUM_W)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [NUM_W-1:0]       num,
   input  logic [DEN_W-1:0]       den,
   output logic [NUM_W-1:0]       quo,
   output wpld_pkg::div_stat_type stat
);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DEN_W:0]   shifted;
   logic [DEN_W+1:0] diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_ff};
      if (!diff[DEN_W+1]) begin
         rem_in = diff[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], 1'b1};
      end else begin
         rem_in = shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
         cnt_ff <= CNT_W'(NUM_W - 1);
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
   end

   assign quo       = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

// ===== sv/windowed_ppb_lock_detector_top.sv =====
`timescale 1ns / 1ps
// Windowed ppb lock detector: window sum over a sample ring, serial divide, classify.
// Depends on wpld_pkg, wpld_chan_if, wpld_ring and wpld_div.
//
// Usage:
//   req_chan carries one signed error sample (cycles per gate second) per
//   transfer; rsp_chan returns exactly one result per sample: the window
//   average in ppb x100, a changed flag, the stability level and the
//   active-low lock level. csr_we/csr_index/csr_wdata write clock_hz (index 0)
//   and lock_threshold (index 1); write them only while the block is idle.
//   A sample passes the states update, multiply, numerator, divide, saturate
//   and finish before rsp_chan.valid rises; the divide state runs a serial
//   divider, one quotient bit per cycle, over NUM_W = 49 + log2(WINDOW_LEN)
//   bits. A new sample is taken once the previous result has left finish.
//   Ring entries not yet written read as zero through the fill count, so no
//   clearing pass runs after reset: reset empties the window, marks the last
//   average invalid and sets the level to unstable.
//   A result waits in the output register while rsp_chan.ready is low; the
//   next sample is still taken and worked on, and only its final step holds
//   until the output register is free.
module windowed_ppb_lock_detector_top #(
   parameter int WINDOW_LEN = 128
) (
   input  logic                               clock,
   input  logic                               reset,
   wpld_req_if.sink                           req_chan,
   wpld_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [wpld_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wpld_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int IDX_W = $clog2(WINDOW_LEN);
   localparam int CNT_W = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W = wpld_pkg::SAMPLE_W + $clog2(WINDOW_LEN);
   localparam int NUM_W = SUM_W + wpld_pkg::SCALE_W;
   localparam int DEN_W = wpld_pkg::CLOCK_W + CNT_W;
   localparam int LO_W  = wpld_pkg::SCALE_LO_W;
   localparam int HI_W  = wpld_pkg::SCALE_HI_W;
   localparam int PPB_W = wpld_pkg::PPB_W;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_LEN);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_LEN - 1);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_UPDATE = 8'b0000_0010,
      ST_MUL    = 8'b0000_0100,
      ST_NUM    = 8'b0000_1000,
      ST_DIV    = 8'b0001_0000,
      ST_SAT    = 8'b0010_0000,
      ST_FIN    = 8'b0100_0000,
      ST_SPARE  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [wpld_pkg::CLOCK_W-1:0]         clock_hz_ff;
   logic [wpld_pkg::THR_W-1:0]           thr_ff;
   logic signed [wpld_pkg::SAMPLE_W-1:0] sample_ff;
   logic signed [wpld_pkg::SAMPLE_W-1:0] ring_rd;
   logic [IDX_W-1:0]                     idx_ff;
   logic [CNT_W-1:0]                     count_ff;
   logic signed [SUM_W-1:0]              sum_ff, sum_in, old_sample;
   logic [SUM_W-1:0]                     sum_mag;
   logic [SUM_W+LO_W-1:0]                pp_lo_ff;
   logic [SUM_W+HI_W-1:0]                pp_hi_ff;
   logic [DEN_W-1:0]                     den_ff;
   logic [wpld_pkg::CLOCK_W-1:0]         clk_eff;
   logic [NUM_W-1:0]                     div_num, div_quo;
   logic                                 div_start;
   wpld_pkg::div_stat_type               div_stat;
   logic                                 q_ovf;
   logic signed [PPB_W-1:0]              avg_ff, avg_in, last_avg_ff;
   logic [PPB_W-1:0]                     amag_ff, amag_in;
   logic                                 avg_valid_ff;
   wpld_pkg::stab_type                   stab_ff, stab_cls, stab_new;
   logic                                 changed;
   logic [PPB_W-1:0]                     thr_ext, thr5;
   logic                                 req_fire, win_full, out_free, fin_go;
   logic                                 rsp_valid_ff;
   logic signed [PPB_W-1:0]              rsp_ppb_ff;
   logic                                 rsp_changed_ff;
   wpld_pkg::stab_type                   rsp_stab_ff;
   logic                                 rsp_lock_n_ff;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= wpld_pkg::CLOCK_HZ_RESET;
         thr_ff      <= wpld_pkg::THRESHOLD_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            wpld_pkg::CSR_CLOCK_HZ:       clock_hz_ff <= csr_wdata[wpld_pkg::CLOCK_W-1:0];
            wpld_pkg::CSR_LOCK_THRESHOLD: thr_ff      <= csr_wdata[wpld_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- ring
   wpld_ring #(.DEPTH(WINDOW_LEN)) u_ring (
      .clock      (clock),
      .rd_en      (req_fire),
      .rd_idx     (idx_ff),
      .rd_data_ff (ring_rd),
      .wr_en      (state_ff == ST_UPDATE),
      .wr_idx     (idx_ff),
      .wr_data    (sample_ff)
   );

   assign req_fire = req_chan.valid && (state_ff == ST_IDLE);
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign win_full = (count_ff == CNT_FULL);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign fin_go   = (state_ff == ST_FIN) && out_free;

   // Entries beyond the fill count were never written and count as zero
   always_comb begin
      old_sample = win_full ? SUM_W'(ring_rd) : '0;
      sum_in     = sum_ff - old_sample + SUM_W'(sample_ff);
      sum_mag    = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      clk_eff    = (clock_hz_ff == '0) ? wpld_pkg::CLOCK_W'(1) : clock_hz_ff;
      div_num    = (NUM_W'(pp_hi_ff) << LO_W) + NUM_W'(pp_lo_ff);
   end

   assign div_start = (state_ff == ST_NUM);

   wpld_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den_ff),
      .quo   (div_quo),
      .stat  (div_stat)
   );

   // Saturate the magnitude quotient into the signed 32-bit range
   always_comb begin
      q_ovf = |div_quo[NUM_W-1:PPB_W-1];
      if (sum_ff[SUM_W-1]) begin
         amag_in = q_ovf ? {1'b1, {(PPB_W-1){1'b0}}} : div_quo[PPB_W-1:0];
         avg_in  = PPB_W'(-amag_in);
      end else begin
         amag_in = q_ovf ? {1'b0, {(PPB_W-1){1'b1}}} : div_quo[PPB_W-1:0];
         avg_in  = PPB_W'(amag_in);
      end
   end

   always_comb begin
      thr_ext = PPB_W'(thr_ff);
      thr5    = (thr_ext << 2) + thr_ext;
      changed = !avg_valid_ff || (avg_ff != last_avg_ff);
      if (!win_full) begin
         stab_cls = wpld_pkg::STAB_UNSTABLE;
      end else if (amag_ff <= thr_ext) begin
         stab_cls = wpld_pkg::STAB_STABLE;
      end else if (amag_ff < thr5) begin
         stab_cls = wpld_pkg::STAB_MARGINAL;
      end else begin
         stab_cls = wpld_pkg::STAB_UNSTABLE;
      end
      stab_new = changed ? stab_cls : stab_ff;
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_chan.valid) state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_MUL;
         ST_MUL:    state_in = ST_NUM;
         ST_NUM:    state_in = ST_DIV;
         ST_DIV:    if (div_stat.done) state_in = ST_SAT;
         ST_SAT:    state_in = ST_FIN;
         ST_FIN:    if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         avg_valid_ff <= 1'b0;
         stab_ff      <= wpld_pkg::STAB_UNSTABLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_UPDATE) begin
            sum_ff <= sum_in;
            idx_ff <= (idx_ff == IDX_LAST) ? '0 : idx_ff + IDX_W'(1);
            if (!win_full) begin
               count_ff <= count_ff + CNT_W'(1);
            end
         end
         if (fin_go) begin
            avg_valid_ff <= 1'b1;
            stab_ff      <= stab_new;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         sample_ff <= req_chan.error_cycles;
      end
      if (state_ff == ST_MUL) begin
         pp_lo_ff <= sum_mag * wpld_pkg::PPB_SCALE_LO;
         pp_hi_ff <= sum_mag * wpld_pkg::PPB_SCALE_HI;
         den_ff   <= DEN_W'(clk_eff) * DEN_W'(count_ff);
      end
      if (state_ff == ST_SAT) begin
         avg_ff  <= avg_in;
         amag_ff <= amag_in;
      end
      if (fin_go) begin
         last_avg_ff    <= avg_ff;
         rsp_ppb_ff     <= avg_ff;
         rsp_changed_ff <= changed;
         rsp_stab_ff    <= stab_new;
         rsp_lock_n_ff  <= (stab_new != wpld_pkg::STAB_STABLE);
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.ppb_x100    = rsp_ppb_ff;
   assign rsp_chan.ppb_changed = rsp_changed_ff;
   assign rsp_chan.stability   = rsp_stab_ff;
   assign rsp_chan.lock_out_n  = rsp_lock_n_ff;

   // ---------------------------------------------------------------- checks
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("sample count beyond window length");

   assert property (@(posedge clock) disable iff (reset)
      !win_full |-> (CNT_W'(idx_ff) == count_ff))
      else $error("write index out of step with fill count");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) && rsp_valid_ff && !rsp_chan.ready |=> (state_ff == ST_FIN))
      else $error("result dropped over a pending output");

endmodule
